// File: design/bab_pkg.sv
// Shared sizes, types and codes for the block allocation bitmap.
package bab_pkg;

    // Default sizes handed to the top level
    localparam int BAB_SLOTS        = 16;
    localparam int BAB_BITMAP_BYTES = 1024;

    // Bitmap storage word: blocks held per memory word
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // Operation codes
    localparam logic [2:0] FN_TEST       = 3'd0;
    localparam logic [2:0] FN_SET        = 3'd1;
    localparam logic [2:0] FN_CLEAR      = 3'd2;
    localparam logic [2:0] FN_FIRST_USED = 3'd3;
    localparam logic [2:0] FN_NEXT_USED  = 3'd4;
    localparam logic [2:0] FN_FIRST_FREE = 3'd5;

    // Status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_DESC  = 2'd1;
    localparam logic [1:0] STS_BAD_BLOCK = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    // Request classes decided after capture
    localparam logic [1:0] K_IMM   = 2'd0;
    localparam logic [1:0] K_POINT = 2'd1;
    localparam logic [1:0] K_SCAN  = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  slot;
        logic [12:0] block;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] found_block;
        logic        bit_value;
        logic        dirty_flag;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic cap;
        logic clr_en;
        logic imm;
        logic rd_first;
        logic point;
        logic scan;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic       clr_last;
        logic [1:0] kind;
        logic       scan_hit;
        logic       scan_last;
        logic       out_free;
    } t_sts;

endpackage

// File: design/bab_dpath.sv
// Datapath: bitmap memory, request decode, word scan, dirty marks and result register.
module bab_dpath
    import bab_pkg::*;
#(
    parameter int SLOTS        = BAB_SLOTS,
    parameter int BITMAP_BYTES = BAB_BITMAP_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_in_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_rsp        o_out_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts
);

    localparam int NBLOCKS   = BITMAP_BYTES * 8;
    localparam int WORDS     = (NBLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W    = SLOT_W + WORD_W;
    localparam int MEM_DEPTH = SLOTS * (2 ** WORD_W);
    localparam int TAIL      = NBLOCKS - WORD_BITS * (WORDS - 1);
    localparam logic [WORD_BITS-1:0] LAST_MASK = WORD_BITS'((64'd1 << TAIL) - 64'd1);
    localparam logic [WORD_W-1:0]    LAST_WORD = WORD_W'(WORDS - 1);
    localparam logic [ADDR_W-1:0]    CLR_LAST  = ADDR_W'(MEM_DEPTH - 1);

    logic [WORD_BITS-1:0] r_mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    t_req              r_req;
    logic [15:0]       r_open_mask;
    logic [SLOTS-1:0]  r_dirty;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [WORD_W-1:0] r_chk_word;
    logic [BIT_W-1:0]  r_sbit;
    logic              r_first;
    logic              r_want;
    logic [1:0]        r_status;
    logic [12:0]       r_found;
    logic              r_bitv;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [31:0]          slot32;
    logic [31:0]          blk32;
    logic [31:0]          start32;
    logic [SLOT_W-1:0]    slot_idx;
    logic                 slot_exists;
    logic                 slot_open;
    logic [1:0]           kind;
    logic [1:0]           imm_status;
    logic                 want;
    logic [WORD_W-1:0]    start_word;
    logic [BIT_W-1:0]     start_bit;
    logic [ADDR_W-1:0]    raddr;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 wen;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 rbit;
    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] cand;
    logic [BIT_W-1:0]     enc_idx;
    logic [31:0]          pos32;
    logic                 dirty_rd;
    logic                 is_write;

    // Decode the held request
    always_comb begin
        slot32      = 32'(r_req.slot);
        blk32       = 32'(r_req.block);
        slot_idx    = slot32[SLOT_W-1:0];
        slot_exists = slot32 < 32'(SLOTS);
        slot_open   = slot_exists && r_open_mask[r_req.slot];
        kind        = K_IMM;
        imm_status  = STS_OK;
        want        = 1'b1;
        start32     = '0;
        if (!slot_open) begin
            imm_status = STS_BAD_DESC;
        end else begin
            unique case (r_req.func) inside
                FN_TEST, FN_SET, FN_CLEAR: begin
                    if (blk32 >= 32'(NBLOCKS)) begin
                        imm_status = STS_BAD_BLOCK;
                    end else begin
                        kind    = K_POINT;
                        start32 = blk32;
                    end
                end
                FN_FIRST_USED: begin
                    kind = K_SCAN;
                end
                FN_NEXT_USED: begin
                    if (blk32 >= 32'(NBLOCKS)) begin
                        imm_status = STS_BAD_BLOCK;
                    end else if (blk32 + 32'd1 >= 32'(NBLOCKS)) begin
                        imm_status = STS_NOT_FOUND;
                    end else begin
                        kind    = K_SCAN;
                        start32 = blk32 + 32'd1;
                    end
                end
                FN_FIRST_FREE: begin
                    kind = K_SCAN;
                    want = 1'b0;
                end
                default: begin
                    imm_status = STS_OK;
                end
            endcase
        end
        start_word = start32[WORD_W+BIT_W-1:BIT_W];
        start_bit  = start32[BIT_W-1:0];
    end

    // Point access on the word read back
    assign is_write = (r_req.func == FN_SET) || (r_req.func == FN_CLEAR);
    assign bit_mask = WORD_BITS'(1) << r_sbit;
    assign rbit     = r_rdata[r_sbit];

    // Scan candidates: skip bits before the start and beyond the map end
    always_comb begin
        low_mask = r_first ? ({WORD_BITS{1'b1}} << r_sbit) : {WORD_BITS{1'b1}};
        cand     = (r_want ? r_rdata : ~r_rdata) & low_mask;
        if (r_chk_word == LAST_WORD) begin
            cand = cand & LAST_MASK;
        end
    end

    // Lowest candidate bit
    always_comb begin
        enc_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                enc_idx = BIT_W'(i);
            end
        end
    end

    assign pos32 = 32'({r_chk_word, enc_idx});

    // Memory port selection
    always_comb begin
        raddr = i_cmd.rd_first ? {slot_idx, start_word} : {slot_idx, r_chk_word + WORD_W'(1)};
        if (i_cmd.clr_en) begin
            waddr = r_clr_addr;
            wdata = '0;
            wen   = 1'b1;
        end else begin
            waddr = {slot_idx, r_chk_word};
            wdata = (r_req.func == FN_SET) ? (r_rdata | bit_mask) : (r_rdata & ~bit_mask);
            wen   = i_cmd.point && is_write;
        end
    end

    // Bitmap memory, registered read
    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // Control state: open mask, dirty marks, clearing sweep, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_mask <= '0;
            r_dirty     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_open_mask <= i_cfg_data;
            end
            if (i_cmd.point && is_write) begin
                r_dirty[slot_idx] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign dirty_rd = slot_exists && r_dirty[slot_idx];

    // Hold request, scan position and staged result
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req <= i_in_data;
        end
        if (i_cmd.imm) begin
            r_status <= imm_status;
            r_found  <= '0;
            r_bitv   <= 1'b0;
        end
        if (i_cmd.rd_first) begin
            r_chk_word <= start_word;
            r_sbit     <= start_bit;
            r_first    <= 1'b1;
            r_want     <= want;
        end
        if (i_cmd.point) begin
            r_status <= STS_OK;
            r_found  <= '0;
            if (r_req.func == FN_SET) begin
                r_bitv <= 1'b1;
            end else if (r_req.func == FN_CLEAR) begin
                r_bitv <= 1'b0;
            end else begin
                r_bitv <= rbit;
            end
        end
        if (i_cmd.scan) begin
            if (|cand) begin
                r_status <= STS_OK;
                r_found  <= pos32[12:0];
                r_bitv   <= r_want;
            end else if (r_chk_word == LAST_WORD) begin
                r_status <= STS_NOT_FOUND;
                r_found  <= '0;
                r_bitv   <= 1'b0;
            end else begin
                r_chk_word <= r_chk_word + WORD_W'(1);
                r_first    <= 1'b0;
            end
        end
        if (i_cmd.out_load) begin
            r_out.status      <= r_status;
            r_out.found_block <= r_found;
            r_out.bit_value   <= r_bitv;
            r_out.dirty_flag  <= dirty_rd;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.clr_last  = (r_clr_addr == CLR_LAST);
        o_sts.kind      = kind;
        o_sts.scan_hit  = |cand;
        o_sts.scan_last = (r_chk_word == LAST_WORD);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // A loaded result is offered on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result not offered after load");

    // A bitmap write during a point access marks the slot dirty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.point && is_write) |=> r_dirty[$past(slot_idx)])
        else $error("dirty mark missing after write");

    // The clearing sweep never overlaps a point write
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en |-> !(i_cmd.point || i_cmd.scan || i_cmd.rd_first))
        else $error("clearing sweep overlaps request work");

endmodule

// File: design/bab_ctrl.sv
// Controller: state machine sequencing clearing, decode, point access, scan and hand-over.
module bab_ctrl
    import bab_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_POINT  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.kind == K_POINT) begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_POINT;
                end else if (i_sts.kind == K_SCAN) begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.imm = 1'b1;
                    n_state   = S_FINISH;
                end
            end
            S_POINT: begin
                o_cmd.point = 1'b1;
                n_state     = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // An accepted request is decoded on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    // A scan stops on a hit or at the end of the map
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (i_sts.scan_hit || i_sts.scan_last)) |=>
        (r_state == S_FINISH))
        else $error("scan did not stop");

    // At most one command per cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.cap, o_cmd.clr_en, o_cmd.imm, o_cmd.rd_first,
                  o_cmd.point, o_cmd.scan, o_cmd.out_load}))
        else $error("conflicting commands");

endmodule

// File: design/block_allocation_bitmap.sv
// Top level of the block allocation bitmap: controller and datapath.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_in_data   (t_req: func, slot, block)
//  out      output     o_out_valid / i_out_ready o_out_data  (t_rsp: status, found_block,
//                                                             bit_value, dirty_flag)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data  (open_mask)
//
//  Test, set and clear requests pass through DECODE, POINT and FINISH; rejected requests
//  go from DECODE straight to FINISH. Scans stay in SCAN for each 32-block bitmap word
//  visited, up to BITMAP_BYTES*8/32 words (256 at default size), read through the single
//  memory read port. After reset a clearing pass zeroes all SLOTS * 2**ceil(log2(words
//  per slot)) memory words (4096 at default size), one word per cycle; no request is
//  taken meanwhile, configuration writes are. The result register lets the next request
//  be accepted while a result waits; a stalled result holds the next one in FINISH.
module block_allocation_bitmap
    import bab_pkg::*;
#(
    parameter int SLOTS        = BAB_SLOTS,
    parameter int BITMAP_BYTES = BAB_BITMAP_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequence each request
    bab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the bitmaps and form results
    bab_dpath #(
        .SLOTS        (SLOTS),
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
